@@ hdl/phase_modulated_sine_oscillator_macros.svh @@
// Assertion macros shared by the oscillator modules.
`ifndef PHASE_MODULATED_SINE_OSCILLATOR_MACROS_SVH
`define PHASE_MODULATED_SINE_OSCILLATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define PMSO_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pmso assertion failed");
`define PMSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmso assertion failed");
`else
`define PMSO_ASSERT(label, clk, rst_n, prop)
`define PMSO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/pmso_pkg.sv @@
// Shared types, constants and table functions of the sine oscillator.
package pmso_pkg;

    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [15:0] FM_GAIN_RESET = 16'd6519;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] ONE_Q30       = 64'd1 << 30;
    localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FREQ  = 6'b000010,
        ST_FM    = 6'b000100,
        ST_ROM   = 6'b001000,
        ST_AMP   = 6'b010000,
        ST_ROUND = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        MUL_FREQ = 2'b00,
        MUL_FM   = 2'b01,
        MUL_AMP  = 2'b10
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        mul_op_t mul_op;
        logic    base_cap;
        logic    rom_rd;
        logic    count_inc;
        logic    out_load;
    } ctrl_t;

    // sin(x) for 0 <= x <= pi/2, Q30 in and out
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[k - 1];
            if (k[0]) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end
            else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] sine_entry(input int idx, input int table_bits,
                                               input int sample_bits);
        logic [63:0] ang;
        logic [63:0] s;
        logic [63:0] peak;
        logic [63:0] e;
        ang  = (HALF_PI_Q30 * 64'(idx) + ((64'd1 << table_bits) >> 1)) >> table_bits;
        s    = sin_q30(ang);
        peak = (64'd1 << (sample_bits - 1)) - 64'd1;
        e    = (s * peak + (ONE_Q30 >> 1)) >> 30;
        if (e > peak) begin
            e = peak;
        end
        return e;
    endfunction

endpackage

@@ hdl/pmso_sine_rom.sv @@
// Quarter-wave sine table with registered read.
module pmso_sine_rom
    import pmso_pkg::*;
#(
    parameter int TABLE_BITS  = TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [TABLE_BITS:0]    rd_addr,
    output logic [SAMPLE_BITS-2:0] rd_data
);

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    typedef logic [SAMPLE_BITS-2:0] entry_t;
    typedef entry_t rom_arr_t [DEPTH];

    function automatic rom_arr_t build_rom();
        rom_arr_t t;
        for (int i = 0; i < DEPTH; i++) begin
            t[i] = entry_t'(sine_entry(i, TABLE_BITS, SAMPLE_BITS));
        end
        return t;
    endfunction

    localparam rom_arr_t SINE_ROM = build_rom();

    logic [SAMPLE_BITS-2:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/pmso_ctrl.sv @@
// Sequencer that steps one sample through the shared multiplier.
`include "phase_modulated_sine_oscillator_macros.svh"

module pmso_ctrl
    import pmso_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_ROUND) && out_free);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ:  state_next = ST_FM;
            ST_FM:    state_next = ST_ROM;
            ST_ROM:   state_next = ST_AMP;
            ST_AMP:   state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_FREQ : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.load      = accept;
        ctrl.mul_en    = (state_reg == ST_FREQ) || (state_reg == ST_FM) ||
                         (state_reg == ST_AMP);
        ctrl.mul_op    = MUL_FREQ;
        case (state_reg)
            ST_FM:   ctrl.mul_op = MUL_FM;
            ST_AMP:  ctrl.mul_op = MUL_AMP;
            default: ctrl.mul_op = MUL_FREQ;
        endcase
        ctrl.base_cap  = (state_reg == ST_FM);
        ctrl.rom_rd    = (state_reg == ST_ROM);
        ctrl.count_inc = (state_reg == ST_FREQ);
        ctrl.out_load  = (state_reg == ST_ROUND) && out_free;
    end

    always_comb
    begin
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `PMSO_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == ST_FREQ)
    `PMSO_ASSERT_NEXT(a_round_holds, clk, rst_n, (state_reg == ST_ROUND) && out_valid_reg && !out_ready, state_reg == ST_ROUND)
    `PMSO_ASSERT_NEXT(a_round_delivers, clk, rst_n, (state_reg == ST_ROUND) && (!out_valid_reg || out_ready), out_valid_reg)

endmodule

@@ hdl/pmso_datapath.sv @@
// Shared multiplier, phase accumulation, table lookup and output rounding.
`include "phase_modulated_sine_oscillator_macros.svh"

module pmso_datapath
    import pmso_pkg::*;
#(
    parameter int TABLE_BITS  = TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  logic [31:0]        freq_word,
    input  logic signed [15:0] amplitude,
    input  logic signed [15:0] fm_in,
    output logic signed [15:0] sample_out
);

    localparam int ADDR_W = TABLE_BITS + 1;
    localparam int AP_W   = 16 + SAMPLE_BITS;
    localparam int PROD_W = (AP_W > 32) ? AP_W : 32;
    localparam logic [ADDR_W-1:0]      ROM_TOP    = ADDR_W'(64'd1 << TABLE_BITS);
    localparam logic signed [AP_W-1:0] ROUND_BIAS = AP_W'(64'd1 << (SAMPLE_BITS - 2));
    localparam logic signed [16:0]     SAT_HI     = 17'sd32767;
    localparam logic signed [16:0]     SAT_LO     = -17'sd32768;

    logic [15:0]               gain_reg;
    logic [31:0]               count_reg;
    logic [31:0]               fw_reg;
    logic signed [15:0]        amp_reg;
    logic signed [15:0]        fm_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [31:0]               base_reg;
    logic                      neg_reg;
    logic signed [15:0]        out_reg;

    logic signed [31:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [63:0]        prod_full;
    logic [31:0]               phase;
    logic [TABLE_BITS-1:0]     k_idx;
    logic [ADDR_W-1:0]         rom_addr;
    logic [SAMPLE_BITS-2:0]    rom_data;
    logic signed [SAMPLE_BITS-1:0] sine_val;
    logic signed [AP_W-1:0]    amp_prod;
    logic signed [AP_W-1:0]    rounded;
    logic signed [16:0]        shifted;
    logic signed [15:0]        sat_val;

    assign sine_val = neg_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

    always_comb
    begin
        case (ctrl.mul_op)
            MUL_FREQ:
            begin
                mul_a = $signed(fw_reg);
                mul_b = $signed(count_reg);
            end
            MUL_FM:
            begin
                mul_a = {{16{fm_reg[15]}}, fm_reg};
                mul_b = $signed({16'b0, gain_reg});
            end
            MUL_AMP:
            begin
                mul_a = {{16{amp_reg[15]}}, amp_reg};
                mul_b = {{(32 - SAMPLE_BITS){sine_val[SAMPLE_BITS-1]}}, sine_val};
            end
            default:
            begin
                mul_a = $signed(fw_reg);
                mul_b = $signed(count_reg);
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // phase = freq * count + (fm * gain) << 5, all modulo one turn
    assign phase    = base_reg + {prod_reg[26:0], 5'b0};
    assign k_idx    = phase[29 -: TABLE_BITS];
    assign rom_addr = phase[30] ? (ROM_TOP - {1'b0, k_idx}) : {1'b0, k_idx};

    pmso_sine_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .clk     (clk),
        .rd_en   (ctrl.rom_rd),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    assign amp_prod = $signed(prod_reg[AP_W-1:0]);
    assign rounded  = amp_prod + ROUND_BIAS;
    assign shifted  = rounded[AP_W-1:SAMPLE_BITS-1];

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            sat_val = 16'sh7FFF;
        end
        else if (shifted < SAT_LO)
        begin
            sat_val = -16'sh8000;
        end
        else
        begin
            sat_val = shifted[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= FM_GAIN_RESET;
            count_reg <= 32'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gain_reg <= cfg_data;
            end
            if (ctrl.count_inc)
            begin
                count_reg <= count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            fw_reg  <= freq_word;
            amp_reg <= amplitude;
            fm_reg  <= fm_in;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (ctrl.base_cap)
        begin
            base_reg <= prod_reg[31:0];
        end
        if (ctrl.rom_rd)
        begin
            neg_reg <= phase[31];
        end
        if (ctrl.out_load)
        begin
            out_reg <= sat_val;
        end
    end

    assign sample_out = out_reg;

    `PMSO_ASSERT_NEXT(a_count_step, clk, rst_n, ctrl.count_inc, count_reg == $past(count_reg) + 32'd1)
    `PMSO_ASSERT(a_rom_addr_range, clk, rst_n, !ctrl.rom_rd || (rom_addr <= ROM_TOP))
    `PMSO_ASSERT_NEXT(a_gain_write, clk, rst_n, cfg_valid, gain_reg == $past(cfg_data))

endmodule

@@ hdl/phase_modulated_sine_oscillator.sv @@
// Top level of the phase-modulated sine oscillator.
// Each request carries a frequency word, an amplitude and a modulation value and
// yields one saturated Q1.15 sample. Each request steps through the states FREQ, FM,
// ROM, AMP and ROUND: one 32x32 multiplier is shared for freq_word * sample count,
// fm_in * fm_gain and amplitude * sine, with the registered quarter-wave table read
// in between. A new request is taken in the cycle the previous result is written, and
// not before; a full output holds it. fm_gain (Q4.12) is written through the cfg channel
// while the block is idle; the user must keep to this, the block does not enforce it.
module phase_modulated_sine_oscillator
    import pmso_pkg::*;
#(
    parameter int TABLE_BITS  = TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        freq_word,
    input  logic signed [15:0] amplitude,
    input  logic signed [15:0] fm_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    pmso_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    pmso_datapath #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .freq_word  (freq_word),
        .amplitude  (amplitude),
        .fm_in      (fm_in),
        .sample_out (sample_out)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the phase-modulated sine oscillator.
module testbench;
    import pmso_pkg::*;

    localparam int ROM_SIZE   = 1 << TABLE_BITS_DEF;
    localparam int INDEX_LSB  = 30 - TABLE_BITS_DEF;
    localparam longint PEAK   = (64'd1 << (SAMPLE_BITS_DEF - 1)) - 1;
    localparam int CYCLE_LIMIT = 500000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [31:0]        freq_word = '0;
    logic signed [15:0] amplitude = '0;
    logic signed [15:0] fm_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] sample_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;

    longint             quarter_sine [0:ROM_SIZE];
    logic [31:0]        model_count = '0;
    logic [15:0]        model_gain = FM_GAIN_RESET;
    logic signed [15:0] expected_samples [$];
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 holdoff_left = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    phase_modulated_sine_oscillator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .freq_word  (freq_word),
        .amplitude  (amplitude),
        .fm_in      (fm_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned taylor_sine(input longint unsigned x);
        longint unsigned sq;
        longint unsigned term;
        longint unsigned acc;
        sq   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end
            else
            begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    task automatic build_quarter_sine();
        longint unsigned angle;
        longint unsigned level;
        for (int i = 0; i <= ROM_SIZE; i++)
        begin
            angle = (HALF_PI_Q30 * 64'(i) + 64'(ROM_SIZE / 2)) / 64'(ROM_SIZE);
            level = (taylor_sine(angle) * 64'(PEAK) + (64'd1 << 29)) >> 30;
            if (level > 64'(PEAK))
            begin
                level = 64'(PEAK);
            end
            quarter_sine[i] = longint'(level);
        end
    endtask

    function automatic logic signed [15:0] predict_sample(input logic [31:0] fw,
                                                          input logic signed [15:0] amp,
                                                          input logic signed [15:0] fm);
        int                      depth;
        logic [31:0]             phase;
        logic [TABLE_BITS_DEF-1:0] idx;
        longint                  level;
        longint                  prod;
        depth = int'(fm) * int'(model_gain);
        phase = fw * model_count + (32'(depth) << 5);
        idx   = phase[INDEX_LSB +: TABLE_BITS_DEF];
        level = phase[30] ? quarter_sine[ROM_SIZE - int'(idx)] : quarter_sine[idx];
        if (phase[31])
        begin
            level = -level;
        end
        prod = longint'(amp) * level + (64'sd1 <<< (SAMPLE_BITS_DEF - 2));
        prod = prod >>> (SAMPLE_BITS_DEF - 1);
        if (prod > 32767)
        begin
            prod = 32767;
        end
        if (prod < -32768)
        begin
            prod = -32768;
        end
        return 16'(prod);
    endfunction

    task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                   input logic signed [15:0] want);
        if (error_count < 40)
        begin
            $display("cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        end
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("phase_modulated_sine_oscillator: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch("unrequested sample_out", sample_out, 16'sd0);
            end
            else
            begin
                if (sample_out !== expected_samples[0])
                begin
                    report_mismatch("sample_out", sample_out, expected_samples[0]);
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            out_ready <= 1'b0;
            holdoff_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_item(input logic [31:0] fw, input logic signed [15:0] amp,
                             input logic signed [15:0] fm);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        freq_word <= fw;
        amplitude <= amp;
        fm_in     <= fm;
        do
            @(posedge clk);
        while (!in_ready);
        expected_samples.push_back(predict_sample(fw, amp, fm));
        model_count = model_count + 32'd1;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_fm_gain(input logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_gain = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hit each quadrant boundary, including the negative peak with the most negative amplitude
    task automatic test_quadrant_peaks();
        for (int i = 0; i < 8; i++)
        begin
            send_item(32'h4000_0000, (i < 4) ? -16'sd32768 : 16'sd32767, 16'sd0);
        end
    endtask

    task automatic test_field_extremes();
        send_item(32'h0000_0000, 16'sd32767, 16'sd0);
        send_item(32'h8000_0000, -16'sd32768, 16'sd32767);
        send_item(32'hFFFF_FFFF, 16'sd32767, -16'sd32768);
        send_item(32'h0000_0001, -16'sd1, -16'sd1);
        send_item(32'h7FFF_FFFF, 16'sd1, 16'sd1);
        send_item(32'hC000_0001, 16'sd0, 16'sd12345);
        send_item(32'h8000_0000, -16'sd32768, -16'sd32768);
        send_item(32'h1234_5678, 16'sd32767, 16'sd32767);
    endtask

    task automatic test_modulation_depths();
        logic [15:0] gains [5];
        gains = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, FM_GAIN_RESET};
        foreach (gains[g])
        begin
            write_fm_gain(gains[g]);
            send_item($urandom_range(65535), 16'sd32767, -16'sd32768);
            send_item($urandom_range(65535), -16'sd32768, 16'sd32767);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [15:0] gain, input int count);
        logic [31:0]        fw;
        logic signed [15:0] amp;
        logic signed [15:0] fm;
        write_fm_gain(gain);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count)
        begin
            case ($urandom_range(5))
                0: fw = $urandom_range(65535);
                1: fw = $urandom() & 32'h7FFF_FFFF;
                2: fw = 32'h8000_0000 - $urandom_range(255);
                3: fw = $urandom();
                4: fw = 32'h8000_0000;
                default: fw = $urandom_range(32'h0400_0000);
            endcase
            case ($urandom_range(7))
                0: amp = 16'sd32767;
                1: amp = -16'sd32768;
                default: amp = 16'($urandom());
            endcase
            case ($urandom_range(7))
                0: fm = 16'sd0;
                1: fm = ($urandom_range(1) == 1) ? 16'sd32767 : -16'sd32768;
                default: fm = 16'($urandom());
            endcase
            send_item(fw, amp, fm);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 16'($urandom()), 330);
        run_random_phase(54, 0, 16'hFFFF, 330);
        run_random_phase(0, 54, 16'h0000, 330);
        run_random_phase(32, 32, FM_GAIN_RESET, 330);
    endtask

    // hold the output long enough that the block backs up into its input
    task automatic test_output_holdoff();
        wait_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holdoff_left       = 300;
        repeat (12)
        begin
            send_item($urandom(), 16'($urandom()), 16'($urandom()));
        end
    endtask

    initial
    begin
        build_quarter_sine();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_quadrant_peaks();
        test_field_extremes();
        test_modulation_depths();
        test_random_traffic();
        test_output_holdoff();
        wait_idle();
        if (error_count == 0)
        begin
            $display("phase_modulated_sine_oscillator: match");
        end
        else
        begin
            $display("phase_modulated_sine_oscillator: mismatch");
        end
        $finish;
    end

endmodule
